/* rtl/core/lkmc_pkg.sv */
// Shared types and constants of the key membership cache.
package lkmc_pkg;

  localparam int MODE_W = 2;
  localparam int WORD_W = 64;
  localparam int KEY_W  = 4 * WORD_W;
  localparam int CFG_W  = 5;
  localparam int OCC_W  = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PROBE = 2'd0,
    MODE_TOUCH = 2'd1,
    MODE_CLEAR = 2'd2
  } lkmc_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_RESP
  } lkmc_state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_PROMOTE,
    OP_INSERT
  } lkmc_op_e;

  typedef struct packed {
    logic     load;
    logic     lookup;
    logic     update;
    lkmc_op_e op;
  } lkmc_cmd_t;

  typedef struct packed {
    lkmc_mode_e mode;
    logic       cap_zero;
    logic       hit;
  } lkmc_status_t;

endpackage

/* rtl/core/lkmc_req_if.sv */
// Request channel: mode and 256-bit key as four words.
interface lkmc_req_if;
  logic                             valid;
  logic                             ready;
  logic [lkmc_pkg::MODE_W-1:0]      mode;
  logic [lkmc_pkg::WORD_W-1:0]      key_word0;
  logic [lkmc_pkg::WORD_W-1:0]      key_word1;
  logic [lkmc_pkg::WORD_W-1:0]      key_word2;
  logic [lkmc_pkg::WORD_W-1:0]      key_word3;

  modport source (
    output valid, mode, key_word0, key_word1, key_word2, key_word3,
    input  ready
  );

  modport sink (
    input  valid, mode, key_word0, key_word1, key_word2, key_word3,
    output ready
  );
endinterface

/* rtl/core/lkmc_rsp_if.sv */
// Response channel: hit flag and occupancy.
interface lkmc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [lkmc_pkg::OCC_W-1:0]  occupancy;

  modport source (
    output valid, hit, occupancy,
    input  ready
  );

  modport sink (
    input  valid, hit, occupancy,
    output ready
  );
endinterface

/* rtl/core/lru_key_membership_cache_top.sv */
// Top level of the fully associative LRU key membership cache.
//
// req_i carries one item: a mode (probe, touch, clear) and a 256-bit key in
// four 64-bit words. rsp_o returns one item per request: the hit flag and
// the number of valid entries after the request is handled.
// cfg_we_i/cfg_wdata_i write the entry capacity (0 disables the cache,
// values above ENTRIES act as ENTRIES); write only while the block is idle.
// The request is loaded into registers, the key is compared against all
// entries into a registered match vector, then the ranks and valid bits
// are updated, and then the response is valid until it is taken. One item
// is handled at a time: a new request is taken only after the response to
// the last one has been taken.
// A stalled response holds its value; req_i.ready stays low until the
// response is taken.
// Reset empties the cache (all entries invalid, occupancy zero) and sets
// the capacity to 16. Key storage is not cleared; no clearing pass is run.
module lru_key_membership_cache_top #(
  parameter int ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lkmc_req_if.sink                     req_i,
  lkmc_rsp_if.source                   rsp_o,
  input  logic                         cfg_we_i,
  input  logic [lkmc_pkg::CFG_W-1:0]   cfg_wdata_i
);

  lkmc_pkg::lkmc_cmd_t    cmd;
  lkmc_pkg::lkmc_status_t status;
  logic                   req_ready;
  logic                   rsp_valid;
  logic                   hit;
  logic [lkmc_pkg::OCC_W-1:0] occupancy;
  logic [lkmc_pkg::KEY_W-1:0] key;

  assign key = {req_i.key_word3, req_i.key_word2, req_i.key_word1, req_i.key_word0};

  lkmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lkmc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (req_i.mode),
    .key_i       (key),
    .cmd_i       (cmd),
    .status_o    (status),
    .hit_o       (hit),
    .occupancy_o (occupancy)
  );

  assign req_i.ready     = req_ready;
  assign rsp_o.valid     = rsp_valid;
  assign rsp_o.hit       = hit;
  assign rsp_o.occupancy = occupancy;

endmodule

/* rtl/core/lkmc_ctrl.sv */
// Controller state machine: sequences load, lookup, update and response.
module lkmc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  output logic                   rsp_valid_o,
  input  logic                   rsp_ready_i,
  input  lkmc_pkg::lkmc_status_t status_i,
  output lkmc_pkg::lkmc_cmd_t    cmd_o
);

  lkmc_pkg::lkmc_state_e state_q, state_d;
  lkmc_pkg::lkmc_op_e    op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkmc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkmc_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          state_d = lkmc_pkg::ST_LOOKUP;
        end
      end
      lkmc_pkg::ST_LOOKUP: state_d = lkmc_pkg::ST_UPDATE;
      lkmc_pkg::ST_UPDATE: state_d = lkmc_pkg::ST_RESP;
      lkmc_pkg::ST_RESP: begin
        if (rsp_ready_i) begin
          state_d = lkmc_pkg::ST_IDLE;
        end
      end
      default: state_d = lkmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op = lkmc_pkg::OP_NONE;
    unique case (status_i.mode) inside
      lkmc_pkg::MODE_CLEAR: op = lkmc_pkg::OP_CLEAR;
      lkmc_pkg::MODE_PROBE, lkmc_pkg::MODE_TOUCH: begin
        if (!status_i.cap_zero) begin
          if (status_i.hit) begin
            op = lkmc_pkg::OP_PROMOTE;
          end else if (status_i.mode == lkmc_pkg::MODE_TOUCH) begin
            op = lkmc_pkg::OP_INSERT;
          end
        end
      end
      default: op = lkmc_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    rsp_valid_o   = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.lookup  = 1'b0;
    cmd_o.update  = 1'b0;
    cmd_o.op      = lkmc_pkg::OP_NONE;
    unique case (state_q)
      lkmc_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      lkmc_pkg::ST_LOOKUP: cmd_o.lookup = 1'b1;
      lkmc_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        cmd_o.op     = op;
      end
      lkmc_pkg::ST_RESP: rsp_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

/* rtl/core/lkmc_datapath.sv */
// Datapath: key rows, valid bits, recency ranks, count and capacity register.
module lkmc_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lkmc_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic [lkmc_pkg::MODE_W-1:0]   mode_i,
  input  logic [lkmc_pkg::KEY_W-1:0]    key_i,
  input  lkmc_pkg::lkmc_cmd_t           cmd_i,
  output lkmc_pkg::lkmc_status_t        status_o,
  output logic                          hit_o,
  output logic [lkmc_pkg::OCC_W-1:0]    occupancy_o
);

  localparam int RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW  = $clog2(ENTRIES + 1);
  localparam int CfgW  = lkmc_pkg::CFG_W;
  localparam int OccW  = lkmc_pkg::OCC_W;
  localparam int CmpW  = (CntW > CfgW) ? CntW : CfgW;

  logic [CfgW-1:0]              cap_cfg_q;
  logic [CntW-1:0]              cap_q;
  lkmc_pkg::lkmc_mode_e         mode_q;
  logic [lkmc_pkg::KEY_W-1:0]   in_key_q;
  logic [lkmc_pkg::KEY_W-1:0]   key_q [ENTRIES];
  logic [ENTRIES-1:0]           valid_q, valid_d;
  logic [RankW-1:0]             rank_q [ENTRIES];
  logic [RankW-1:0]             rank_d [ENTRIES];
  logic [CntW-1:0]              count_q, count_d;
  logic [ENTRIES-1:0]           match_q;
  logic                         hit_q;

  logic [RankW-1:0]             hit_rank;
  logic [CntW-1:0]              cap_m1;
  logic [ENTRIES-1:0]           evict;
  logic [ENTRIES-1:0]           keep;
  logic [ENTRIES-1:0]           free_oh;
  logic [CntW-1:0]              count_ins;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= lkmc_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_cfg_q <= cfg_wdata_i;
    end
  end

  logic [CntW-1:0] cap_load;
  assign cap_load = (CmpW'(cap_cfg_q) > CmpW'(ENTRIES)) ? CntW'(ENTRIES)
                                                         : CntW'(cap_cfg_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_key_q <= key_i;
      mode_q   <= lkmc_pkg::lkmc_mode_e'(mode_i);
      cap_q    <= cap_load;
    end
    if (cmd_i.lookup) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match_q[i] <= valid_q[i] && (key_q[i] == in_key_q);
      end
    end
    if (cmd_i.update) begin
      hit_q <= (cmd_i.op == lkmc_pkg::OP_PROMOTE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && cmd_i.op == lkmc_pkg::OP_INSERT) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (free_oh[i]) begin
          key_q[i] <= in_key_q;
        end
      end
    end
  end

  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank = hit_rank | (match_q[i] ? rank_q[i] : '0);
    end
  end

  assign cap_m1 = cap_q - CntW'(1);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      evict[i] = valid_q[i] && (CntW'(rank_q[i]) >= cap_m1);
    end
  end

  assign keep      = valid_q & ~evict;
  assign free_oh   = ~keep & (keep + ENTRIES'(1));
  assign count_ins = ((count_q > cap_m1) ? cap_m1 : count_q) + CntW'(1);

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (cmd_i.update) begin
      case (cmd_i.op)
        lkmc_pkg::OP_CLEAR: begin
          valid_d = '0;
          count_d = '0;
          for (int i = 0; i < ENTRIES; i++) begin
            rank_d[i] = '0;
          end
        end
        lkmc_pkg::OP_PROMOTE: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (match_q[i]) begin
              rank_d[i] = '0;
            end else if (valid_q[i] && rank_q[i] < hit_rank) begin
              rank_d[i] = rank_q[i] + RankW'(1);
            end
          end
        end
        lkmc_pkg::OP_INSERT: begin
          valid_d = keep | free_oh;
          count_d = count_ins;
          for (int i = 0; i < ENTRIES; i++) begin
            if (keep[i]) begin
              rank_d[i] = rank_q[i] + RankW'(1);
            end else begin
              rank_d[i] = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  assign status_o.mode     = mode_q;
  assign status_o.cap_zero = (cap_q == '0);
  assign status_o.hit      = |match_q;

  assign hit_o       = hit_q;
  assign occupancy_o = OccW'(count_q);

endmodule
